### sv/hmti_pkg.sv
`default_nettype none
package hmti_pkg;

  // Table geometry.
  localparam int TABLE_ROWS = 16;
  localparam int ROWS_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Divider geometry: 64-bit dividend, divisor of up to 33 bits.
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_MODE = 1'd1;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE  = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SUM = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [3:0]  row_index;
    logic [31:0] break_x;
    logic [31:0] break_y;
    logic [31:0] temperature;
    logic [31:0] neighbor_temperature;
    logic        neighbor_present;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  status;
  } out_item_t;

  // Search token that travels down the row cells.
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] key;
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] y0;
    logic [31:0] y1;
  } search_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_HMUL, S_HGO, S_HDIV, S_INJECT, S_SEARCH,
    S_IMUL, S_IGO, S_IDIV, S_RESULT
  } state_t;

endpackage
`default_nettype wire

### sv/hmti_cell.sv
`default_nettype none
module hmti_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   wr_en,
  input  wire  [31:0]           wr_x,
  input  wire  [31:0]           wr_y,
  input  wire  [31:0]           next_x,
  input  wire  [31:0]           next_y,
  input  wire                   search_on,
  input  hmti_pkg::search_t     sin,
  output logic [31:0]           row_x,
  output logic [31:0]           row_y,
  output hmti_pkg::search_t     sout
);
  import hmti_pkg::*;

  logic hit;

  // Row storage, written by load transactions.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_x <= wr_x;
      row_y <= wr_y;
    end
  end

  // This row's segment holds the key when x[j] <= key < x[j+1].
  assign hit = sin.valid && !sin.found && search_on &&
               ($signed(sin.key) >= $signed(row_x)) &&
               ($signed(sin.key) < $signed(next_x));

  // Hand the token to the next cell; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      sout.valid <= 1'b0;
    end else begin
      sout.valid <= sin.valid;
    end
    sout.found <= sin.found | hit;
    sout.key   <= sin.key;
    if (hit) begin
      sout.x0 <= row_x;
      sout.x1 <= next_x;
      sout.y0 <= row_y;
      sout.y1 <= next_y;
    end else begin
      sout.x0 <= sin.x0;
      sout.x1 <= sin.x1;
      sout.y0 <= sin.y0;
      sout.y1 <= sin.y1;
    end
  end

endmodule
`default_nettype wire

### sv/hmti_div.sv
`default_nettype none
module hmti_div (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] dividend,
  input  wire  [32:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);
  import hmti_pkg::*;

  logic [63:0]          dvd;
  logic [33:0]          rem;
  logic [32:0]          dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [33:0]          shifted;
  logic [34:0]          diff;
  logic                 ge;

  // One restoring step: shift in a dividend bit, subtract when it fits.
  assign shifted = {rem[32:0], dvd[63]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign ge      = !diff[34];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      rem <= ge ? diff[33:0] : shifted;
      dvd <= {dvd[62:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign quotient = dvd;

endmodule
`default_nettype wire

### sv/harmonic_mean_table_interpolator.sv
`default_nettype none
// Breakpoint table interpolator in signed Q16.16. Kind-0 transactions write one
// (x, y) row and return 0 with status ok; kind-1 transactions form a key (the
// temperature, or in harmonic mode 2ab/(a+b) with a neighbor and 0 without one)
// and return the linearly interpolated, saturated y with a status. One item is
// handled at a time. An evaluation walks the key through the row of TABLE_ROWS
// cells, then a 64-step divider forms the quotient; a harmonic key is computed
// first on the same divider. The result waits in an output register until
// taken. Configuration writes are accepted in any cycle.
module harmonic_mean_table_interpolator (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  hmti_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output hmti_pkg::out_item_t                   out_data,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [hmti_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [hmti_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import hmti_pkg::*;

  state_t state, state_next;

  logic [ROWS_W-1:0] rows_in_use;
  logic              harmonic_mode;
  logic [ROWS_W-1:0] rows_eff;

  logic [31:0] a_r, b_r, key_r;
  logic        present_r;
  logic [32:0] sum_mag_r;
  logic        neg_r;
  logic [63:0] prod_r;
  logic [31:0] t_r, dymag_r, dx_r, y0_r;
  logic        dy_neg_r;
  out_item_t   res_r;

  logic accept, load_out, div_start, inject;
  logic [32:0] sum;
  logic [31:0] a_mag, b_mag;
  logic        sum_zero;

  logic [63:0] div_q;
  logic        div_done;
  logic [63:0] div_dividend;
  logic [32:0] div_divisor;

  search_t     links [TABLE_ROWS+1];
  logic [31:0] cell_x [TABLE_ROWS];
  logic [31:0] cell_y [TABLE_ROWS];
  search_t     tail;

  logic [31:0] hkey;
  logic [32:0] dy;
  logic [33:0] dq, delta, isum;
  logic [31:0] ival;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign tail      = links[TABLE_ROWS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= ROWS_W'(2);
      harmonic_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE:   rows_in_use   <= cfg_data[ROWS_W-1:0];
        REG_HARMONIC_MODE: harmonic_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the row count to the table.
  assign rows_eff = (rows_in_use < ROWS_W'(2)) ? ROWS_W'(2) :
                    ((int'(rows_in_use) > TABLE_ROWS) ? ROWS_W'(TABLE_ROWS) : rows_in_use);

  // Key preparation arithmetic.
  assign sum      = {a_r[31], a_r} + {b_r[31], b_r};
  assign sum_zero = (sum == '0);
  assign a_mag    = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign b_mag    = b_r[31] ? (~b_r + 32'd1) : b_r;

  // Row of cells holding the table; the search token enters at cell 0.
  always_comb begin
    links[0]       = '0;
    links[0].valid = inject;
    links[0].key   = key_r;
  end

  for (genvar j = 0; j < TABLE_ROWS; j++) begin : g_cell
    logic [31:0] nx, ny;
    if (j == TABLE_ROWS - 1) begin : g_last
      assign nx = '0;
      assign ny = '0;
    end else begin : g_mid
      assign nx = cell_x[j+1];
      assign ny = cell_y[j+1];
    end
    hmti_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (accept && in_data.kind == KIND_LOAD && int'(in_data.row_index) == j),
      .wr_x      (in_data.break_x),
      .wr_y      (in_data.break_y),
      .next_x    (nx),
      .next_y    (ny),
      .search_on ((j + 1) < int'(rows_eff)),
      .sin       (links[j]),
      .row_x     (cell_x[j]),
      .row_y     (cell_y[j]),
      .sout      (links[j+1])
    );
  end

  // Shared divider for the harmonic key and the interpolation quotient.
  assign div_dividend = (state == S_HGO) ? {prod_r[62:0], 1'b0} : prod_r;
  assign div_divisor  = (state == S_HGO) ? sum_mag_r : {1'b0, dx_r};

  hmti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // Harmonic key: sign and saturate the quotient.
  always_comb begin
    if (neg_r) begin
      hkey = (div_q > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~div_q[31:0] + 32'd1);
    end else begin
      hkey = (div_q > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
    end
  end

  // Interpolation: y0 plus the signed quotient, saturated.
  assign dy    = {tail.y1[31], tail.y1} - {tail.y0[31], tail.y0};
  assign dq    = {1'b0, div_q[32:0]};
  assign delta = dy_neg_r ? (~dq + 34'd1) : dq;
  assign isum  = {{2{y0_r[31]}}, y0_r} + delta;
  always_comb begin
    if (!isum[33] && isum[32:31] != 2'b00) begin
      ival = 32'h7FFF_FFFF;
    end else if (isum[33] && isum[32:31] != 2'b11) begin
      ival = 32'h8000_0000;
    end else begin
      ival = isum[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_data.kind == KIND_LOAD) ? S_RESULT : S_PREP;
        end
      end
      S_PREP: begin
        if (!harmonic_mode || !present_r) begin
          state_next = S_INJECT;
        end else if (sum_zero) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_HMUL;
        end
      end
      S_HMUL:   state_next = S_HGO;
      S_HGO:    state_next = S_HDIV;
      S_HDIV:   if (div_done) state_next = S_INJECT;
      S_INJECT: state_next = S_SEARCH;
      S_SEARCH: begin
        if (tail.valid) begin
          state_next = tail.found ? S_IMUL : S_RESULT;
        end
      end
      S_IMUL:   state_next = S_IGO;
      S_IGO:    state_next = S_IDIV;
      S_IDIV:   if (div_done) state_next = S_RESULT;
      S_RESULT: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    inject    = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      S_IDLE:   in_ready  = 1'b1;
      S_HGO:    div_start = 1'b1;
      S_IGO:    div_start = 1'b1;
      S_INJECT: inject    = 1'b1;
      S_RESULT: load_out  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        a_r       <= in_data.temperature;
        b_r       <= in_data.neighbor_temperature;
        present_r <= in_data.neighbor_present;
        res_r     <= '{result_value: 32'd0, status: STATUS_OK};
      end
      S_PREP: begin
        key_r     <= (harmonic_mode && !present_r) ? 32'd0 : a_r;
        sum_mag_r <= sum[32] ? (~sum + 33'd1) : sum;
        neg_r     <= (a_r[31] ^ b_r[31]) ^ sum[32];
        if (harmonic_mode && present_r && sum_zero) begin
          res_r <= '{result_value: 32'd0, status: STATUS_ZERO_SUM};
        end
      end
      S_HMUL: prod_r <= 64'(a_mag) * 64'(b_mag);
      S_HDIV: if (div_done) key_r <= hkey;
      S_SEARCH: begin
        t_r      <= tail.key - tail.x0;
        dx_r     <= tail.x1 - tail.x0;
        y0_r     <= tail.y0;
        dy_neg_r <= dy[32];
        dymag_r  <= dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
        if (tail.valid && !tail.found) begin
          res_r <= '{result_value: 32'd0, status: STATUS_OUTSIDE};
        end
      end
      S_IMUL: prod_r <= 64'(t_r) * 64'(dymag_r);
      S_IDIV: if (div_done) res_r <= '{result_value: ival, status: STATUS_OK};
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res_r;
    end
  end

endmodule
`default_nettype wire

### sv/hmti_checker.sv
`default_nettype none
module hmti_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input hmti_pkg::out_item_t  out_data
);
  import hmti_pkg::*;

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: the block is busy right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_OUTSIDE ||
                   out_data.status == STATUS_ZERO_SUM))
    else $error("undefined status");

  // Non-ok results carry zero.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_OK |-> out_data.result_value == 32'd0)
    else $error("nonzero value with error status");

endmodule

bind harmonic_mean_table_interpolator hmti_checker u_hmti_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
